>>> hw/rtl/dpc_pkg.sv
`default_nettype none
package dpc_pkg;
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_COUNT = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_CYCLE = 2'd3;

   localparam int CFG_W   = 7;
   localparam int COUNT_W = 32;

   // node numbers travel in 6-bit fields, so the node space is fixed
   localparam int MAX_NODES = 64;
endpackage
`default_nettype wire

>>> hw/rtl/dpc_edge_mem.sv
`default_nettype none
module dpc_edge_mem #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/dag_path_counter.sv
`default_nettype none
// DAG path counter. Each request clears the graph, adds one edge, or counts the
// paths from node 0 to every sink (a node without outgoing edges). Exactly one
// result follows each request, strobed on rsp_valid for one cycle; the receiver
// cannot stall, so keep it ready whenever a request is out. busy is high from
// acceptance through the result cycle, and only one request is in flight.
// A clear strobes its result in the cycle after acceptance. An add-edge strobes
// it after a degree read, then an edge and degree write. A count runs a
// depth-first walk through the degree, edge, count and stack memories and
// strobes its result when the walk ends; a stale edge or a cycle ends the
// walk at the edge where it is met. csr_ready is high while idle.
module dag_path_counter
   import dpc_pkg::*;
#(
   parameter int MAX_DEGREE = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_func,
   input  wire logic [5:0]          req_src_node,
   input  wire logic [5:0]          req_dst_node,
   output logic                     rsp_valid,
   output logic [COUNT_W-1:0]       rsp_path_count,
   output logic [1:0]               rsp_status,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CFG_W-1:0]    csr_data
);
   localparam int NW = $clog2(MAX_NODES);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int EW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int AW = $clog2(MAX_NODES * MAX_DEGREE);
   localparam int SW = $clog2(MAX_NODES + 1);
   localparam int CW = $clog2(MAX_NODES + 1) > CFG_W ? $clog2(MAX_NODES + 1) : CFG_W;

   localparam logic [3:0] S_IDLE = 4'd0, S_ADD = 4'd1, S_INIT = 4'd2,
      S_TOP = 4'd3, S_TOP2 = 4'd4, S_EDGE = 4'd5, S_VIS = 4'd6,
      S_VIS2 = 4'd7, S_POP = 4'd8, S_POP2 = 4'd9, S_DONE = 4'd10,
      S_PUSH = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [CFG_W-1:0] cfg_ff;
   logic [5:0] src_ff, dst_ff;
   logic [1:0] status_ff, status_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   // per-node flags; a clear drops every degree by dropping its valid bit
   logic [MAX_NODES-1:0] memo_v_ff, onstk_ff, deg_v_ff;

   // degrees, walk stack and counts held in memories
   logic [DW-1:0]      deg_mem  [MAX_NODES];
   logic [NW-1:0]      stk_node [MAX_NODES];
   logic [DW-1:0]      stk_edge [MAX_NODES];
   logic [COUNT_W-1:0] memo_mem [MAX_NODES];

   logic [SW-1:0] sp_ff, sp_in;
   logic [NW-1:0] u_ff, u_in, v_ff, v_in;
   logic [DW-1:0] e_ff, e_in, ud_ff, ud_in;
   logic [COUNT_W-1:0] acc_ff, acc_in, child_cnt_ff;

   logic [CW-1:0] n_act;
   always_comb begin
      if (cfg_ff == '0) n_act = CW'(1);
      else if (CW'(cfg_ff) > CW'(MAX_NODES)) n_act = CW'(MAX_NODES);
      else n_act = CW'(cfg_ff);
   end

   // degree memory: registered read, valid bit zeroes entries not yet written
   logic [NW-1:0] deg_ra;
   logic [DW-1:0] deg_rd_ff, deg_cur;
   logic          deg_hit_ff;
   assign deg_cur = deg_hit_ff ? deg_rd_ff : '0;

   // edge memory
   logic edge_we;
   logic [AW-1:0] edge_wa, edge_ra;
   logic [5:0] edge_rd;
   dpc_edge_mem #(.DEPTH(MAX_NODES * MAX_DEGREE), .WIDTH(6)) u_edge (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(dst_ff),
      .rd_addr(edge_ra), .rd_data(edge_rd)
   );

   assign edge_we = (state_ff == S_ADD) && (status_in == STATUS_OK);
   assign edge_wa = AW'(src_ff[NW-1:0]) * AW'(MAX_DEGREE) + AW'(deg_cur[EW-1:0]);
   assign edge_ra = AW'(u_ff) * AW'(MAX_DEGREE) + AW'(e_ff[EW-1:0]);

   always_ff @(posedge clock) begin
      if (edge_we) deg_mem[src_ff[NW-1:0]] <= deg_cur + DW'(1);
      deg_rd_ff  <= deg_mem[deg_ra];
      deg_hit_ff <= deg_v_ff[deg_ra];
   end

   // stack/memo memory ports: registered reads
   logic [NW-1:0]      stk_n_rd_ff;
   logic [DW-1:0]      stk_e_rd_ff;
   logic [COUNT_W-1:0] memo_rd_ff;
   logic               stk_we, memo_we;
   logic [NW-1:0]      stk_wa, stk_ra, memo_wa, memo_ra;
   logic [NW-1:0]      stk_wn;
   logic [DW-1:0]      stk_we_e;
   logic [COUNT_W-1:0] memo_wd;

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_node[stk_wa] <= stk_wn;
         stk_edge[stk_wa] <= stk_we_e;
      end
      stk_n_rd_ff <= stk_node[stk_ra];
      stk_e_rd_ff <= stk_edge[stk_ra];
      if (memo_we) memo_mem[memo_wa] <= memo_wd;
      memo_rd_ff <= memo_mem[memo_ra];
   end

   logic [NW-1:0] top_idx;
   assign top_idx = NW'(sp_ff - SW'(1));

   // stale edge: stored under a larger node count than the current one
   logic v_range;
   assign v_range = (CW'(edge_rd) >= n_act);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      total_in  = total_ff;
      sp_in = sp_ff; u_in = u_ff; v_in = v_ff; e_in = e_ff; ud_in = ud_ff;
      acc_in = acc_ff;
      stk_we = 1'b0; stk_wa = top_idx; stk_wn = u_ff; stk_we_e = e_ff;
      stk_ra = top_idx;
      memo_we = 1'b0; memo_wa = u_ff; memo_wd = acc_ff; memo_ra = v_ff;
      deg_ra = u_ff;
      case (state_ff)
         S_IDLE: begin
            // fetch the source's degree for an add, node 0's for a count
            deg_ra = (req_func == FUNC_COUNT) ? '0 : req_src_node[NW-1:0];
            if (start) begin
               status_in = STATUS_OK;
               total_in  = '0;
               case (req_func)
                  FUNC_CLEAR: state_in = S_DONE;
                  FUNC_ADD:   state_in = S_ADD;
                  FUNC_COUNT: state_in = S_INIT;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_ADD: begin
            if ((CW'(src_ff) >= n_act) || (CW'(dst_ff) >= n_act))
               status_in = STATUS_RANGE;
            else if (deg_cur >= DW'(MAX_DEGREE))
               status_in = STATUS_FULL;
            state_in = S_DONE;
         end
         S_INIT: begin
            // push node 0
            u_in = '0; e_in = '0; ud_in = deg_cur;
            acc_in = (deg_cur == '0) ? COUNT_W'(1) : '0;
            sp_in = SW'(1);
            state_in = S_EDGE;
         end
         S_TOP: begin
            // parent node known: fetch its saved count and its degree
            state_in = S_TOP2;
            memo_ra = stk_n_rd_ff;
            deg_ra = stk_n_rd_ff;
         end
         S_TOP2: begin
            // restore the parent's frame and add the finished child's count
            u_in = stk_n_rd_ff; e_in = stk_e_rd_ff; ud_in = deg_cur;
            acc_in = memo_rd_ff + child_cnt_ff;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            if (e_ff < ud_ff) begin
               state_in = S_VIS;  // edge read in flight
            end else begin
               state_in = S_POP;
            end
         end
         S_VIS: begin
            e_in = e_ff + DW'(1);
            if (v_range) begin
               status_in = STATUS_RANGE; state_in = S_DONE;
            end else begin
               v_in = NW'(edge_rd);
               memo_ra = NW'(edge_rd);
               deg_ra = NW'(edge_rd);
               if (memo_v_ff[NW'(edge_rd)]) state_in = S_VIS2;
               else if (onstk_ff[NW'(edge_rd)]) begin
                  status_in = STATUS_CYCLE; state_in = S_DONE;
               end else begin
                  // save current frame, push child
                  stk_we = 1'b1; stk_wa = top_idx; stk_wn = u_ff;
                  stk_we_e = e_ff + DW'(1);
                  memo_we = 1'b1; memo_wa = u_ff; memo_wd = acc_ff;
                  sp_in = sp_ff + SW'(1);
                  u_in = NW'(edge_rd); e_in = '0;
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            // child's degree is back: a sink starts with one path
            ud_in = deg_cur;
            acc_in = (deg_cur == '0) ? COUNT_W'(1) : '0;
            state_in = S_EDGE;
         end
         S_VIS2: begin
            acc_in = acc_ff + memo_rd_ff;
            state_in = S_EDGE;
         end
         S_POP: begin
            memo_we = 1'b1; memo_wa = u_ff; memo_wd = acc_ff;
            sp_in = sp_ff - SW'(1);
            if (sp_ff == SW'(1)) begin
               total_in = acc_ff; state_in = S_DONE;
            end else begin
               state_in = S_POP2;
            end
         end
         S_POP2: begin
            // parent's saved frame read from stack
            stk_ra = top_idx;
            state_in = S_TOP;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cfg_ff    <= CFG_W'(1);
         memo_v_ff <= '0;
         onstk_ff  <= '0;
         deg_v_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) cfg_ff <= csr_data;
         if (state_ff == S_IDLE && start) begin
            src_ff <= req_src_node; dst_ff <= req_dst_node;
            if (req_func == FUNC_CLEAR) deg_v_ff <= '0;
            if (req_func == FUNC_COUNT) begin
               memo_v_ff <= '0; onstk_ff <= '0;
            end
         end
         if (edge_we) deg_v_ff[src_ff[NW-1:0]] <= 1'b1;
         if (state_ff == S_INIT) onstk_ff[0] <= 1'b1;
         if (state_ff == S_VIS && !v_range && !memo_v_ff[NW'(edge_rd)]
             && !onstk_ff[NW'(edge_rd)])
            onstk_ff[NW'(edge_rd)] <= 1'b1;
         if (state_ff == S_POP) begin
            memo_v_ff[u_ff] <= 1'b1; onstk_ff[u_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in; total_ff <= total_in;
      sp_ff <= sp_in; u_ff <= u_in; v_ff <= v_in; e_ff <= e_in; ud_ff <= ud_in;
      acc_ff <= acc_in;
      // hold the finished child's count until the parent's saved count is back
      if (state_ff == S_POP) child_cnt_ff <= acc_ff;
   end

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_DONE);
   assign rsp_path_count = (status_ff == STATUS_OK) ? total_ff : '0;
   assign rsp_status     = status_ff;
endmodule
`default_nettype wire
